### rtl/sli_pkg.sv
// Shared types and codes for the ordered list engine.
package sli_pkg;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 7;

    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    localparam logic [COUNT_W-1:0] MAX_ENTRIES_RESET = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_CEILING     = 7'd127;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                      status;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        count;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_FIND   = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    typedef struct packed {
        logic start;     // latch the accepted operation
        logic init;      // latch the decoded kind and set the shift index
        logic rd_find;   // read the entry addressed by the position
        logic cap_rval;  // capture the read data as the result value
        logic rd_shift;  // read the next entry to be moved
        logic wr_shift;  // write the moved entry and step the index
        logic put;       // final insert write and count update
        logic load_out;  // load the result register
    } t_cmd;

    typedef struct packed {
        t_kind kind;     // decode of the latched operation against the count
        logic  more;     // another entry still has to move
        logic  out_free; // result register can take a new beat
    } t_status;

endpackage

### rtl/sli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sli_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sli_ctrl.sv
// Controller state machine that sequences each list operation.
module sli_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_in_stall,
    output sli_pkg::t_cmd    o_cmd,
    input  sli_pkg::t_status i_sts
);

    import sli_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_FRD    = 6'b000100,
        S_SRD    = 6'b001000,
        S_SWR    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.start = 1'b1;
                    n_state   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.init = 1'b1;
                unique case (i_sts.kind)
                    KIND_FIND: begin
                        cmd.rd_find = 1'b1;
                        n_state     = S_FRD;
                    end
                    KIND_INSERT, KIND_DELETE: begin
                        n_state = S_SRD;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_FRD: begin
                cmd.cap_rval = 1'b1;
                n_state      = S_DONE;
            end
            S_SRD: begin
                if (i_sts.more) begin
                    cmd.rd_shift = 1'b1;
                    n_state      = S_SWR;
                end else begin
                    cmd.put = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_SWR: begin
                cmd.wr_shift = 1'b1;
                n_state      = S_SRD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;

    // A write of a moved entry always uses the data read in the cycle before.
    a_swr_after_srd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWR) |-> ($past(r_state) == S_SRD))
        else $error("shift write without a preceding shift read");

endmodule

### rtl/sli_dp.sv
// Datapath: list store, entry count, limit register, shift index and result register.
module sli_dp #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sli_pkg::t_in_item             i_item,
    input  logic                          i_cfg_we,
    input  logic [sli_pkg::COUNT_W-1:0]   i_cfg_data,
    input  sli_pkg::t_cmd                 i_cmd,
    output sli_pkg::t_status              o_sts,
    output logic                          o_valid,
    input  logic                          i_stall,
    output sli_pkg::t_out_item            o_item
);

    import sli_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned IW = (AW > COUNT_W) ? AW : COUNT_W;
    localparam logic [COUNT_W-1:0] DEPTH_CAP =
        (DEPTH > 127) ? COUNT_CEILING : COUNT_W'(DEPTH);

    function automatic logic [AW-1:0] to_addr(input logic [COUNT_W-1:0] x);
        logic [IW-1:0] w;
        w = IW'(x);
        return w[AW-1:0];
    endfunction

    logic [FUNC_W-1:0]         r_func;
    logic [POS_W-1:0]          r_pos;
    logic signed [VALUE_W-1:0] r_value;
    t_kind                     r_kind;
    logic [COUNT_W-1:0]        r_j;
    logic [COUNT_W-1:0]        r_count;
    logic [COUNT_W-1:0]        r_max;
    logic signed [VALUE_W-1:0] r_rval;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic [COUNT_W-1:0] pos_ext;
    logic [COUNT_W-1:0] limit;
    t_kind              dec_kind;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    assign pos_ext = COUNT_W'(r_pos);
    assign limit   = (r_max > DEPTH_CAP) ? DEPTH_CAP : r_max;

    always_comb begin
        dec_kind = KIND_ERROR;
        case (r_func)
            FUNC_FIND: begin
                if ((pos_ext < r_count) && (32'(r_pos) < DEPTH)) begin
                    dec_kind = KIND_FIND;
                end
            end
            FUNC_INSERT: begin
                if ((pos_ext <= r_count) && (r_count < limit)) begin
                    dec_kind = KIND_INSERT;
                end
            end
            FUNC_DELETE: begin
                if ((r_count != '0) && (pos_ext < r_count)) begin
                    dec_kind = KIND_DELETE;
                end
            end
            default: begin
                dec_kind = KIND_ERROR;
            end
        endcase
    end

    // An insert moves entries up from the top down to the slot; a delete
    // moves them down from just above the position up to the top.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = to_addr(r_j);
        ram_wdata = ram_rdata;
        ram_raddr = to_addr(pos_ext);
        if (i_cmd.rd_find) begin
            ram_raddr = to_addr(pos_ext);
        end
        if (i_cmd.rd_shift) begin
            ram_raddr = (r_kind == KIND_INSERT) ? to_addr(r_j - 7'd1) : to_addr(r_j);
        end
        if (i_cmd.wr_shift) begin
            ram_we    = 1'b1;
            ram_waddr = (r_kind == KIND_INSERT) ? to_addr(r_j) : to_addr(r_j - 7'd1);
        end
        if (i_cmd.put && (r_kind == KIND_INSERT)) begin
            ram_we    = 1'b1;
            ram_waddr = to_addr(pos_ext);
            ram_wdata = r_value;
        end
    end

    sli_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func  <= i_item.func;
            r_pos   <= i_item.position;
            r_value <= i_item.value;
            r_rval  <= '0;
        end
        if (i_cmd.init) begin
            r_kind <= dec_kind;
            r_j    <= (dec_kind == KIND_INSERT) ? r_count : pos_ext + 7'd1;
        end
        if (i_cmd.cap_rval) begin
            r_rval <= ram_rdata;
        end
        if (i_cmd.wr_shift) begin
            r_j <= (r_kind == KIND_INSERT) ? r_j - 7'd1 : r_j + 7'd1;
        end
        if (i_cmd.load_out) begin
            r_out.status     <= (r_kind == KIND_ERROR);
            r_out.read_value <= r_rval;
            r_out.count      <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_max       <= MAX_ENTRIES_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            if (i_cmd.put) begin
                r_count <= (r_kind == KIND_INSERT) ? r_count + 7'd1 : r_count - 7'd1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.kind     = dec_kind;
    assign o_sts.more     = (r_kind == KIND_INSERT) ? (r_j > pos_ext) : (r_j < r_count);
    assign o_sts.out_free = !r_out_valid || !i_stall;
    assign o_valid        = r_out_valid;
    assign o_item         = r_out;

    // The count can never grow past the capacity of the store.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CAP)
        else $error("entry count beyond store capacity");

    // Only the final step of a successful insert or delete changes the count.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !i_cmd.put) |=> $stable(r_count))
        else $error("entry count changed outside an update step");

    // A refused operation never writes the store.
    a_no_write_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind == KIND_ERROR && !i_cmd.init) |-> !ram_we)
        else $error("store written by a refused operation");

endmodule

### rtl/sequential_list_insert_delete.sv
// Ordered list engine: positional find, insert and delete over a store of entries.
//
// Input channel: i_valid / o_stall carry one i_item beat (func, position, value).
// Output channel: o_valid / i_stall carry one o_item beat (status, read_value,
// count) for every accepted input beat, in order.
// Configuration: i_cfg_we writes i_cfg_data into the max_entries limit; write it
// only while no operation is outstanding.
// The block works on one operation at a time. After acceptance it decodes the
// operation against the count. A refused operation then goes straight to the
// result load; a find reads the addressed entry; an insert moves count - position
// entries and a delete count - position - 1, then the final step writes an
// inserted value and updates the count. Each moved entry costs a read step and a
// write step, as the list RAM registers its read data. The next beat is taken in
// the cycle after the result is loaded into the output register.
// The output register lets the next input beat be taken while a result still
// waits; a stalled receiver holds the result and, once the next operation is
// done, holds the engine in its final step until the register frees.
// Reset empties the list (count 0) and sets max_entries to 64; entry contents
// are not cleared, as only written entries are ever read.
module sequential_list_insert_delete #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  sli_pkg::t_in_item           i_item,
    output logic                        o_valid,
    input  logic                        i_stall,
    output sli_pkg::t_out_item          o_item,
    input  logic                        i_cfg_we,
    input  logic [sli_pkg::COUNT_W-1:0] i_cfg_data
);

    import sli_pkg::*;

    t_cmd    cmd;
    t_status sts;

    sli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_in_stall (o_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    sli_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

endmodule

### dv/sequential_list_insert_delete_tb.sv
// Self-checking testbench for the ordered list engine: directed, pressure and random list traffic.
module sequential_list_insert_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sli_pkg::*;

    localparam int unsigned DEPTH = 64;
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned DRAIN_CYCLES = 150;
    localparam int unsigned PHASES = 14;
    localparam int unsigned PHASE_ITEMS = 78;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef enum int {MIX_GROW, MIX_CHURN, MIX_SHRINK} t_mix;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in_item in_item = '0;
    logic out_valid;
    logic rx_stall = 1'b0;
    t_out_item out_item;
    logic cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_data = '0;

    // Shadow of the list held by the block.
    logic signed [VALUE_W-1:0] list_mem [DEPTH];
    logic [COUNT_W-1:0] list_len = '0;
    logic [COUNT_W-1:0] max_entries_cfg = MAX_ENTRIES_RESET;
    t_out_item pending_results[$];

    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned refused_ops = 0;
    int unsigned peak_len = 0;
    int unsigned limit_settings = 0;
    int unsigned backpressure_cycles = 0;
    int unsigned stall_pct = 0;
    int unsigned burst_left = 0;
    bit sender_gaps = 1'b0;
    bit hold_pending = 1'b0;

    sequential_list_insert_delete #(.DEPTH(DEPTH)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_item     (in_item),
        .o_valid    (out_valid),
        .i_stall    (rx_stall),
        .o_item     (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Applies one operation to the shadow list and returns the result it should give.
    function automatic t_out_item apply_list_op(input t_in_item op);
        t_out_item res;
        int unsigned lim;
        int unsigned j;
        res.status = 1'b1;
        res.read_value = '0;
        lim = (max_entries_cfg > DEPTH) ? DEPTH : max_entries_cfg;
        case (op.func)
            FUNC_FIND: begin
                if (op.position < list_len) begin
                    res.read_value = list_mem[op.position];
                    res.status = 1'b0;
                end
            end
            FUNC_INSERT: begin
                if (op.position <= list_len && list_len < lim) begin
                    for (j = list_len; j > op.position; j--)
                        list_mem[j] = list_mem[j-1];
                    list_mem[op.position] = op.value;
                    list_len++;
                    res.status = 1'b0;
                end
            end
            FUNC_DELETE: begin
                if (list_len != 0 && op.position < list_len) begin
                    for (j = op.position + 1; j < list_len; j++)
                        list_mem[j-1] = list_mem[j];
                    list_len--;
                    res.status = 1'b0;
                end
            end
            default: ;
        endcase
        res.count = list_len;
        if (res.status)
            refused_ops++;
        if (list_len > peak_len)
            peak_len = list_len;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (mismatches < 40)
            $display("%0t: result %0d, %s is %0d, expected %0d", $realtime, results_seen, field,
                     got, want);
        mismatches++;
    endtask

    // Every beat taken on the input side adds its expected result.
    always @(posedge clk) begin
        if (rst_n && in_valid) begin
            if (!in_stall)
                pending_results.push_back(apply_list_op(in_item));
            else
                backpressure_cycles++;
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !rx_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat, count", out_item.count, -1);
            end else begin
                want = pending_results.pop_front();
                if (out_item.status !== want.status)
                    report_mismatch("status", out_item.status, want.status);
                if (out_item.read_value !== want.read_value)
                    report_mismatch("read_value", out_item.read_value, want.read_value);
                if (out_item.count !== want.count)
                    report_mismatch("count", out_item.count, want.count);
            end
            results_seen++;
        end
    end

    // Receiver: random stall pattern, with an occasional long hold-off on request.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                rx_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            rx_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_item(input t_in_item op);
        if (sender_gaps && burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_item <= op;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_op(input logic [FUNC_W-1:0] func, input int unsigned pos,
                           input logic signed [VALUE_W-1:0] value);
        t_in_item op;
        op.func = func;
        op.position = POS_W'(pos);
        op.value = value;
        send_item(op);
    endtask

    // Lowers valid and waits until every beat sent so far has come back.
    task automatic wait_results_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_seen < items_sent)
            @(posedge clk);
    endtask

    task automatic write_max_entries(input logic [COUNT_W-1:0] limit);
        cfg_we <= 1'b1;
        cfg_data <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
        max_entries_cfg = limit;
        limit_settings++;
    endtask

    // Mostly legal positions for the current length, with some noise beats mixed in.
    function automatic t_in_item make_list_op(input t_mix mix);
        t_in_item op;
        int unsigned len;
        int unsigned roll;
        int unsigned ins_pct;
        int unsigned find_pct;
        len = list_len;
        op.value = $urandom;
        if ($urandom_range(0, 99) < 5) begin
            case ($urandom_range(0, 3))
                0: op.value = 32'sh7fff_ffff;
                1: op.value = 32'sh8000_0000;
                2: op.value = '0;
                default: op.value = '1;
            endcase
        end
        if ($urandom_range(0, 99) < 8) begin
            op.func = FUNC_W'($urandom_range(0, 3));
            op.position = POS_W'($urandom_range(0, 63));
            return op;
        end
        case (mix)
            MIX_GROW: begin
                ins_pct = 65;
                find_pct = 20;
            end
            MIX_CHURN: begin
                ins_pct = 35;
                find_pct = 35;
            end
            default: begin
                ins_pct = 15;
                find_pct = 25;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
            op.func = FUNC_INSERT;
            op.position = POS_W'((len > 63) ? $urandom_range(0, 63) : $urandom_range(0, len));
        end else begin
            op.func = (roll < ins_pct + find_pct) ? FUNC_FIND : FUNC_DELETE;
            if (len == 0 || $urandom_range(0, 9) == 0)
                op.position = POS_W'($urandom_range(0, 63));
            else
                op.position = POS_W'($urandom_range(0, len - 1));
        end
        return op;
    endfunction

    task automatic test_empty_list();
        send_op(FUNC_FIND, 0, 32'sd5);
        send_op(FUNC_DELETE, 0, 32'sd0);
        send_op(FUNC_INSERT, 1, 32'sd9);
        send_op(FUNC_UNUSED, 0, 32'sd1);
        send_op(FUNC_INSERT, 0, 32'sh7fff_ffff);
        send_op(FUNC_FIND, 0, '1);
        send_op(FUNC_FIND, 1, 32'sd0);
        send_op(FUNC_FIND, 63, 32'sd0);
        wait_results_done();
    endtask

    task automatic test_shifting();
        // Front insert moves the entry up; end and mid-list inserts follow; a past-end one fails.
        send_op(FUNC_INSERT, 0, 32'sh8000_0000);
        send_op(FUNC_INSERT, 2, '1);
        send_op(FUNC_INSERT, 1, 32'sd0);
        send_op(FUNC_INSERT, 5, 32'sd7);
        for (int unsigned p = 0; p < 4; p++)
            send_op(FUNC_FIND, p, 32'sd0);
        send_op(FUNC_DELETE, 1, 32'sd0);
        send_op(FUNC_FIND, 1, 32'sd0);
        send_op(FUNC_DELETE, 3, 32'sd0);
        send_op(FUNC_DELETE, 2, 32'sd0);
        send_op(FUNC_DELETE, 63, 32'sd0);
        wait_results_done();
    endtask

    task automatic test_limits();
        // The list holds two entries here, so a limit of two already refuses an insert.
        write_max_entries(7'd2);
        send_op(FUNC_INSERT, 0, 32'sd11);
        wait_results_done();
        write_max_entries(7'd0);
        send_op(FUNC_INSERT, 2, 32'sd12);
        send_op(FUNC_DELETE, 0, 32'sd0);
        send_op(FUNC_DELETE, 0, 32'sd0);
        send_op(FUNC_INSERT, 0, 32'sd13);
        wait_results_done();
    endtask

    task automatic test_backpressure();
        stall_pct = 0;
        sender_gaps = 1'b0;
        hold_pending = 1'b1;
        for (int unsigned n = 0; n < 30; n++)
            send_item(make_list_op(MIX_CHURN));
        // Sender now waits for the whole backlog before carrying on.
        wait_results_done();
    endtask

    task automatic test_random_traffic();
        logic [COUNT_W-1:0] cfg_plan [PHASES] =
            '{7'd127, 7'd64, 7'd127, 7'd5, 7'd0, 7'd3, 7'd2, 7'd1, 7'd100, 7'd64,
              7'd20, 7'd127, 7'd40, 7'd64};
        t_mix mix_plan [PHASES] =
            '{MIX_GROW, MIX_CHURN, MIX_GROW, MIX_SHRINK, MIX_SHRINK, MIX_CHURN, MIX_CHURN,
              MIX_SHRINK, MIX_GROW, MIX_CHURN, MIX_CHURN, MIX_GROW, MIX_SHRINK, MIX_SHRINK};
        int unsigned stall_plan [PHASES] =
            '{0, 30, 60, 10, 0, 50, 20, 80, 0, 40, 25, 70, 10, 0};
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            wait_results_done();
            write_max_entries((ph == 10) ? 7'($urandom_range(0, 127)) : cfg_plan[ph]);
            stall_pct = stall_plan[ph];
            sender_gaps = (ph % 4 != 0);
            burst_left = 0;
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
                send_item(make_list_op(mix_plan[ph]));
        end
        wait_results_done();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sender_gaps = 1'b1;
        stall_pct = 30;
        test_empty_list();
        test_shifting();
        test_limits();
        write_max_entries(7'd127);
        test_backpressure();
        test_random_traffic();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d operations, %0d refused, over %0d limit settings; list peaked at %0d.",
                 items_sent, refused_ops, limit_settings, peak_len);
        $display("Input held back on %0d cycles; %0d results checked, %0d mismatches.",
                 backpressure_cycles, results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (pending_results.size() != 0)
                $display("%0d expected results never arrived", pending_results.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("Timed out with %0d of %0d results seen", results_seen, items_sent);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
